FILE: design/lag_pkg.sv
// Shared types and constants for the life automaton generation block.
// Holds the grid limits, field widths, transaction structs and codes.
// No dependencies.
package lag_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [0:0] {
    OP_SET  = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic             opcode;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]    row_index;
    logic [MAX_COLS-1:0] row_cells;
    logic                coord_error;
    logic                stable;
    logic                last;
  } out_item_t;

endpackage

FILE: design/life_automaton_generation.sv
// Game of Life (B3/S23) generation engine over a grid of up to 64 x 64 cells.
// Depends on lag_pkg, lag_ram and lag_rule.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): a set-cell transaction marks
//   one cell alive; a step transaction computes one generation.
//   Output channel (out_valid/out_ready/out_data): one result per set-cell,
//   one result per row in use per step, row 0 first; last marks the final.
//   Config port (cfg_we/cfg_index/cfg_data): rows and columns in use; write
//   only while the block is idle. Zero acts as 1, above 64 acts as 64.
// Flow:
//   Set cell: S_SET_RD reads the row, then S_SET_WR modifies it, writes it
//   back and loads the result, waiting while the output register is full.
//   Step: the grid RAM is read once per row through a three-row window and
//   one new row is written back and emitted per cycle while the output
//   register is free. One transaction is in work at a time.
// Reset: every row reads as dead through per-row valid flags, so no clearing
//   pass is needed; the registers return to 64 x 64.
// Stall: while a result waits in the output register the sweep holds; the
//   RAM read register keeps its data until the sweep advances.
module life_automaton_generation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lag_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lag_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [lag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lag_pkg::SIZE_W-1:0]    cfg_data
);
  import lag_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SET_RD = 4'b0010,
    S_SET_WR = 4'b0100,
    S_STEP   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   rows_r, cols_r;
  logic [SIZE_W-1:0]   eff_rows, eff_cols;
  logic [MAX_COLS-1:0] col_mask;

  in_item_t            item_r, item_nxt;
  logic                err_r, err_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  logic                same_r, same_nxt;
  logic                rd_live_r, rd_live_nxt;
  logic                rd_vld_r;
  logic [MAX_ROWS-1:0] row_vld_r;

  out_item_t           out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free, out_load;

  logic                ram_we, ram_re;
  logic [ROW_W-1:0]    ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;
  logic [MAX_COLS-1:0] rd_row, incoming, new_row;
  logic [ROW_W-1:0]    emit_row;
  logic                is_last, row_same;

  // effective sizes: saturate into 1..MAX
  always_comb begin
    if (rows_r == '0) begin
      eff_rows = SIZE_W'(1);
    end else if (rows_r > SIZE_W'(MAX_ROWS)) begin
      eff_rows = SIZE_W'(MAX_ROWS);
    end else begin
      eff_rows = rows_r;
    end
    if (cols_r == '0) begin
      eff_cols = SIZE_W'(1);
    end else if (cols_r > SIZE_W'(MAX_COLS)) begin
      eff_cols = SIZE_W'(MAX_COLS);
    end else begin
      eff_cols = cols_r;
    end
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (SIZE_W'(i) < eff_cols);
    end
  end

  lag_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS),
    .AW    (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a row never written reads as dead
  assign rd_row   = rd_vld_r ? ram_rdata : '0;
  assign incoming = rd_live_r ? rd_row : '0;

  lag_rule u_rule (
    .up_row   (up_r),
    .mid_row  (mid_r),
    .dn_row   (incoming),
    .col_mask (col_mask),
    .new_row  (new_row)
  );

  assign out_free = !out_valid_r || out_ready;
  assign emit_row = ROW_W'(cnt_r - CNT_W'(2));
  assign is_last  = (cnt_r == (eff_rows + SIZE_W'(1)));
  assign row_same = (new_row == (mid_r & col_mask));

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    err_nxt      = err_r;
    cnt_nxt      = cnt_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    same_nxt     = same_r;
    rd_live_nxt  = rd_live_r;
    out_data_nxt = out_data_r;
    out_load     = 1'b0;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = item_r.cell_row;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = item_r.cell_row;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.opcode == OP_STEP) begin
            cnt_nxt   = '0;
            up_nxt    = '0;
            mid_nxt   = '0;
            same_nxt  = 1'b1;
            state_nxt = S_STEP;
          end else begin
            state_nxt = S_SET_RD;
          end
        end
      end
      S_SET_RD: begin
        err_nxt   = (SIZE_W'(item_r.cell_row) >= eff_rows) ||
                    (SIZE_W'(item_r.cell_col) >= eff_cols);
        ram_re    = !err_nxt;
        state_nxt = S_SET_WR;
      end
      S_SET_WR: begin
        ram_wdata = rd_row | (MAX_COLS'(1) << item_r.cell_col);
        if (out_free) begin
          ram_we                   = !err_r;
          out_load                 = 1'b1;
          out_data_nxt.row_index   = item_r.cell_row;
          out_data_nxt.row_cells   = err_r ? '0 : (ram_wdata & col_mask);
          out_data_nxt.coord_error = err_r;
          out_data_nxt.stable      = 1'b0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_STEP: begin
        if (out_free) begin
          // read ahead two rows; emit row cnt-2 from the window
          ram_re      = (cnt_r < CNT_W'(eff_rows));
          ram_raddr   = cnt_r[ROW_W-1:0];
          rd_live_nxt = ram_re;
          if (cnt_r >= CNT_W'(1)) begin
            up_nxt  = mid_r;
            mid_nxt = incoming;
          end
          if (cnt_r >= CNT_W'(2)) begin
            ram_we                   = 1'b1;
            ram_waddr                = emit_row;
            ram_wdata                = (mid_r & ~col_mask) | new_row;
            same_nxt                 = same_r && row_same;
            out_load                 = 1'b1;
            out_data_nxt.row_index   = emit_row;
            out_data_nxt.row_cells   = new_row;
            out_data_nxt.coord_error = 1'b0;
            out_data_nxt.stable      = is_last && same_r && row_same;
            out_data_nxt.last        = is_last;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      rows_r      <= SIZE_W'(MAX_ROWS);
      cols_r      <= SIZE_W'(MAX_COLS);
      rd_live_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_live_r   <= rd_live_nxt;
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_r <= row_vld_r[ram_raddr];
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows_r <= cfg_data;
          CFG_COLS: cols_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    err_r      <= err_nxt;
    cnt_r      <= cnt_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    same_r     <= same_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the window sweep never writes the row it is reading
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid RAM read and write hit the same row");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (cnt_r <= CNT_W'(eff_rows + SIZE_W'(1))))
    else $error("step sweep ran past the last row");

  a_stable_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.stable || out_data_r.last))
    else $error("stable flag on a row that is not last");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.coord_error) |-> (out_data_r.row_cells == '0))
    else $error("coordinate error result carries cells");

  a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP && out_free && is_last) |=> (state_r == S_IDLE && out_valid_r))
    else $error("step did not finish after the last row");

endmodule

FILE: design/lag_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data updates only on a read enable and holds otherwise.
// No dependencies.
module lag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lag_rule.sv
// B3/S23 next-row logic: one lane per column over a three-row window.
// Depends on lag_pkg for the column count.
module lag_rule (
  input  logic [lag_pkg::MAX_COLS-1:0] up_row,
  input  logic [lag_pkg::MAX_COLS-1:0] mid_row,
  input  logic [lag_pkg::MAX_COLS-1:0] dn_row,
  input  logic [lag_pkg::MAX_COLS-1:0] col_mask,
  output logic [lag_pkg::MAX_COLS-1:0] new_row
);
  import lag_pkg::*;

  logic [MAX_COLS+1:0] up_pad;
  logic [MAX_COLS+1:0] mid_pad;
  logic [MAX_COLS+1:0] dn_pad;
  logic [3:0]          nbr_cnt [MAX_COLS];
  logic [MAX_COLS-1:0] alive;

  // pad with dead cells so the edges need no special case
  assign up_pad  = {1'b0, up_row  & col_mask, 1'b0};
  assign mid_pad = {1'b0, mid_row & col_mask, 1'b0};
  assign dn_pad  = {1'b0, dn_row  & col_mask, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr_cnt[c] = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
                 + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
                 + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
      alive[c] = (nbr_cnt[c] == 4'd3) || (mid_pad[c+1] && (nbr_cnt[c] == 4'd2));
    end
  end

  assign new_row = alive & col_mask;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for life_automaton_generation: set-cell and generation-step transactions.
// A scoreboard class tracks the cell grid and the grid size, and checks each emitted row.
// Depends on lag_pkg and the life_automaton_generation RTL.
module testbench;
  import lag_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned MAX_REPORTS = 25;

  class life_tracker;
    logic [MAX_COLS-1:0] cells [MAX_ROWS];
    logic [SIZE_W-1:0]   rows_reg;
    logic [SIZE_W-1:0]   cols_reg;
    out_item_t           pending_rows [$];
    int unsigned         mismatches;
    int unsigned         commands;
    int unsigned         steps;
    int unsigned         coord_errors;
    int unsigned         rows_checked;

    function new();
      foreach (cells[i]) cells[i] = '0;
      rows_reg = SIZE_W'(MAX_ROWS);
      cols_reg = SIZE_W'(MAX_COLS);
      mismatches = 0;
      commands = 0;
      steps = 0;
      coord_errors = 0;
      rows_checked = 0;
    endfunction

    function void write_size(cfg_index_t idx, logic [SIZE_W-1:0] value);
      if (idx == CFG_ROWS) rows_reg = value;
      else cols_reg = value;
    endfunction

    // Zero acts as one, anything past the maximum saturates.
    function int unsigned live_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int unsigned live_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
    endfunction

    function logic [MAX_COLS-1:0] live_mask();
      if (live_cols() >= MAX_COLS) return '1;
      return (64'd1 << live_cols()) - 64'd1;
    endfunction

    function int unsigned pending_count();
      return pending_rows.size();
    endfunction

    function void apply_command(in_item_t cmd);
      int unsigned         nrows;
      int unsigned         ncols;
      int unsigned         cnt;
      logic [MAX_COLS-1:0] mask;
      logic [MAX_COLS-1:0] cur;
      logic [MAX_COLS-1:0] up;
      logic [MAX_COLS-1:0] dn;
      logic [MAX_COLS-1:0] nrow;
      logic [MAX_COLS-1:0] fresh [MAX_ROWS];
      bit                  same;
      out_item_t           want;
      nrows = live_rows();
      ncols = live_cols();
      mask = live_mask();
      commands++;
      if (cmd.opcode == OP_SET) begin
        want = '0;
        want.row_index = cmd.cell_row;
        want.last = 1'b1;
        if (cmd.cell_row >= nrows || cmd.cell_col >= ncols) begin
          want.coord_error = 1'b1;
          coord_errors++;
        end else begin
          cells[cmd.cell_row][cmd.cell_col] = 1'b1;
          want.row_cells = cells[cmd.cell_row] & mask;
        end
        pending_rows.push_back(want);
        return;
      end
      steps++;
      same = 1'b1;
      for (int r = 0; r < nrows; r++) begin
        cur = cells[r] & mask;
        up = (r > 0) ? (cells[r-1] & mask) : '0;
        dn = (r + 1 < nrows) ? (cells[r+1] & mask) : '0;
        nrow = '0;
        for (int c = 0; c < ncols; c++) begin
          cnt = up[c] + dn[c];
          if (c > 0) cnt = cnt + up[c-1] + cur[c-1] + dn[c-1];
          if (c + 1 < ncols) cnt = cnt + up[c+1] + cur[c+1] + dn[c+1];
          nrow[c] = cur[c] ? (cnt == 2 || cnt == 3) : (cnt == 3);
        end
        fresh[r] = nrow;
        if (nrow != cur) same = 1'b0;
      end
      // Cells outside the grid in use keep their value.
      for (int r = 0; r < nrows; r++) begin
        cells[r] = (cells[r] & ~mask) | fresh[r];
        want = '0;
        want.row_index = ROW_W'(r);
        want.row_cells = fresh[r];
        want.last = (r + 1 == nrows);
        want.stable = (r + 1 == nrows) && same;
        pending_rows.push_back(want);
      end
    endfunction

    task report_mismatch(string field, logic [MAX_COLS-1:0] want, logic [MAX_COLS-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: mismatch on %s, expected %h, got %h (row result %0d)",
                 $time, field, want, got, rows_checked);
    endtask

    task check_row(out_item_t got);
      out_item_t want;
      rows_checked++;
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got.row_index);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index)
        report_mismatch("row_index", want.row_index, got.row_index);
      if (got.row_cells !== want.row_cells)
        report_mismatch("row_cells", want.row_cells, got.row_cells);
      if (got.coord_error !== want.coord_error)
        report_mismatch("coord_error", want.coord_error, got.coord_error);
      if (got.stable !== want.stable)
        report_mismatch("stable", want.stable, got.stable);
      if (got.last !== want.last)
        report_mismatch("last", want.last, got.last);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROWS;
  logic [SIZE_W-1:0]     cfg_data = '0;

  bit                    idle_on = 1'b1;
  int unsigned           cycle_count = 0;
  life_tracker           tracker = new();

  life_automaton_generation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_row(out_data);
  end

  function automatic in_item_t make_cmd(opcode_t op, logic [ROW_W-1:0] row,
                                        logic [COL_W-1:0] col);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.cell_row = row;
    cmd.cell_col = col;
    return cmd;
  endfunction

  // Hold valid across back-to-back transactions; drop it only for a gap.
  task automatic send_command(in_item_t cmd);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    tracker.apply_command(cmd);
  endtask

  task automatic step_grid();
    send_command(make_cmd(OP_STEP, ROW_W'($urandom), COL_W'($urandom)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid_size(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    tracker.write_size(CFG_ROWS, rows);
    cfg_index <= CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    tracker.write_size(CFG_COLS, cols);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return SIZE_W'(MAX_ROWS);
      2: return SIZE_W'($urandom_range(127, 65));
      3: return SIZE_W'($urandom_range(63, 17));
      default: return SIZE_W'($urandom_range(16, 1));
    endcase
  endfunction

  initial begin
    int unsigned roll;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid: corners, a blinker, one generation.
    set_grid_size(7'd64, 7'd64);
    send_command(make_cmd(OP_SET, 6'd0, 6'd0));
    send_command(make_cmd(OP_SET, 6'd63, 6'd63));
    send_command(make_cmd(OP_SET, 6'd0, 6'd63));
    send_command(make_cmd(OP_SET, 6'd63, 6'd0));
    send_command(make_cmd(OP_SET, 6'd5, 6'd4));
    send_command(make_cmd(OP_SET, 6'd5, 6'd5));
    send_command(make_cmd(OP_SET, 6'd5, 6'd6));
    step_grid();
    drain_results();

    // 4 x 4: still-life block, coordinates just past the edges.
    set_grid_size(7'd4, 7'd4);
    send_command(make_cmd(OP_SET, 6'd1, 6'd1));
    send_command(make_cmd(OP_SET, 6'd1, 6'd2));
    send_command(make_cmd(OP_SET, 6'd2, 6'd1));
    send_command(make_cmd(OP_SET, 6'd2, 6'd2));
    send_command(make_cmd(OP_SET, 6'd4, 6'd0));
    send_command(make_cmd(OP_SET, 6'd0, 6'd4));
    step_grid();
    step_grid();
    drain_results();

    // Zero rows acts as one; oversize columns saturate.
    set_grid_size(7'd0, 7'd127);
    send_command(make_cmd(OP_SET, 6'd0, 6'd63));
    send_command(make_cmd(OP_SET, 6'd63, 6'd0));
    step_grid();
    drain_results();

    set_grid_size(7'd127, 7'd0);
    send_command(make_cmd(OP_SET, 6'd63, 6'd0));
    send_command(make_cmd(OP_SET, 6'd0, 6'd1));
    step_grid();
    drain_results();

    // Grow back: hidden cells reappear.
    set_grid_size(7'd64, 7'd64);
    step_grid();
    step_grid();
    drain_results();

    for (int phase = 0; phase < 10; phase++) begin
      set_grid_size(pick_size(), pick_size());
      idle_on = (phase != 4);
      for (int n = 0; n < 45; n++) begin
        roll = $urandom_range(99);
        if (roll < 22)
          step_grid();
        else if (roll < 32)
          send_command(make_cmd(OP_SET, ROW_W'($urandom), COL_W'($urandom)));
        else
          send_command(make_cmd(OP_SET,
                                ROW_W'($urandom_range(tracker.live_rows() - 1)),
                                COL_W'($urandom_range(tracker.live_cols() - 1))));
      end
      drain_results();
    end
    idle_on = 1'b1;
    repeat (70) @(posedge clk);

    $display("Covered %0d transactions: %0d generation steps, %0d out-of-grid sets",
             tracker.commands, tracker.steps, tracker.coord_errors);
    $display("Compared %0d result rows, %0d mismatches", tracker.rows_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: life_automaton_generation.f
design/lag_pkg.sv
design/lag_ram.sv
design/lag_rule.sv
design/life_automaton_generation.sv
verif/testbench.sv
